// ----- rtl/core/hcomp_pkg.sv -----
// Shared types, register indexes and constants of the humidity and temperature compensation block.
package hcomp_pkg;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_CAL_ONE      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_CAL_TWO      = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_CAL_THREE    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_CAL_ONE       = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_CAL_TWO       = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_CAL_THREE     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_CAL_FOUR_FIVE = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_CAL_SIX       = 4'd7;

   // Reset values of the calibration registers
   localparam logic [15:0] TEMP_CAL_ONE_RST      = 16'd27698;
   localparam logic [15:0] TEMP_CAL_TWO_RST      = 16'hFE66;   // -410
   localparam logic [15:0] TEMP_CAL_THREE_RST    = 16'd189;
   localparam logic [7:0]  HUM_CAL_ONE_RST       = 8'd75;
   localparam logic [15:0] HUM_CAL_TWO_RST       = 16'd356;
   localparam logic [7:0]  HUM_CAL_THREE_RST     = 8'd0;
   localparam logic [23:0] HUM_CAL_FOUR_FIVE_RST = 24'd0;
   localparam logic [7:0]  HUM_CAL_SIX_RST       = 8'd30;

   // Formula constants
   localparam logic signed [31:0] FINE_OFFSET   = 32'sd76800;
   localparam logic signed [31:0] HUM_ROUND_L   = 32'sd16384;
   localparam logic signed [31:0] HUM_BIAS_R    = 32'sd2097152;
   localparam logic signed [31:0] HUM_BIAS_Y    = 32'sd32768;
   localparam logic signed [31:0] HUM_ROUND_R   = 32'sd8192;
   localparam logic signed [31:0] HUM_CLAMP_MAX = 32'sd419430400;
   localparam logic signed [34:0] TEMP_ROUND    = 35'sd128;
   localparam logic signed [26:0] TEMP_SAT_MAX  = 27'sd8388607;
   localparam logic signed [26:0] TEMP_SAT_MIN  = -27'sd8388608;

   // Datapath step codes, issued in order by the controller
   localparam int unsigned STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_T_LIN   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_T_SQ    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_T_FINE  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_H_LEFT  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_H_X     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_H_Y     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_H_INNER = 4'd6;
   localparam logic [STEP_W-1:0] STEP_H_RIGHT = 4'd7;
   localparam logic [STEP_W-1:0] STEP_H_PROD  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_H_SQ    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_H_CORR  = 4'd10;

   localparam logic KIND_TEMPERATURE = 1'b0;
   localparam logic KIND_HUMIDITY    = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [19:0] raw_value;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [23:0] temperature_centi;
      logic [16:0]        humidity_q10;
      logic [6:0]         humidity_percent;
   } rsp_type;

   typedef struct packed {
      logic [15:0] temp_cal_one;
      logic [15:0] temp_cal_two;
      logic [15:0] temp_cal_three;
      logic [7:0]  hum_cal_one;
      logic [15:0] hum_cal_two;
      logic [7:0]  hum_cal_three;
      logic [23:0] hum_cal_four_five;
      logic [7:0]  hum_cal_six;
   } cal_type;

   typedef struct packed {
      logic              load;
      logic              exec;
      logic              write_out;
      logic [STEP_W-1:0] step;
   } cmd_type;

endpackage

// ----- rtl/core/hcomp_csr.sv -----
// Calibration register file written through the configuration port.
module hcomp_csr import hcomp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cal_type                cal
);

   cal_type cal_ff;
   cal_type cal_in;

   always_comb begin
      cal_in = cal_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TEMP_CAL_ONE:      cal_in.temp_cal_one      = csr_wdata[15:0];
            CSR_TEMP_CAL_TWO:      cal_in.temp_cal_two      = csr_wdata[15:0];
            CSR_TEMP_CAL_THREE:    cal_in.temp_cal_three    = csr_wdata[15:0];
            CSR_HUM_CAL_ONE:       cal_in.hum_cal_one       = csr_wdata[7:0];
            CSR_HUM_CAL_TWO:       cal_in.hum_cal_two       = csr_wdata[15:0];
            CSR_HUM_CAL_THREE:     cal_in.hum_cal_three     = csr_wdata[7:0];
            CSR_HUM_CAL_FOUR_FIVE: cal_in.hum_cal_four_five = csr_wdata[23:0];
            CSR_HUM_CAL_SIX:       cal_in.hum_cal_six       = csr_wdata[7:0];
            default:               cal_in = cal_ff;   // unused indexes are ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.temp_cal_one      <= TEMP_CAL_ONE_RST;
         cal_ff.temp_cal_two      <= TEMP_CAL_TWO_RST;
         cal_ff.temp_cal_three    <= TEMP_CAL_THREE_RST;
         cal_ff.hum_cal_one       <= HUM_CAL_ONE_RST;
         cal_ff.hum_cal_two       <= HUM_CAL_TWO_RST;
         cal_ff.hum_cal_three     <= HUM_CAL_THREE_RST;
         cal_ff.hum_cal_four_five <= HUM_CAL_FOUR_FIVE_RST;
         cal_ff.hum_cal_six       <= HUM_CAL_SIX_RST;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign cal = cal_ff;

endmodule

// ----- rtl/core/hcomp_ctrl.sv -----
// Controller state machine that sequences the datapath steps and owns the handshakes.
module hcomp_ctrl import hcomp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_kind,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff,     state_in;
   logic [STEP_W-1:0] step_ff,      step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   // The output register may be refilled in the cycle its item is taken.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.load      = 1'b0;
      cmd.exec      = 1'b0;
      cmd.write_out = 1'b0;
      cmd.step      = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = (req_kind == KIND_HUMIDITY) ? STEP_H_LEFT : STEP_T_LIN;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.exec = 1'b1;
            if (step_ff == STEP_T_FINE || step_ff == STEP_H_CORR) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.write_out = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_T_LIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/hcomp_dp.sv -----
// Datapath with one shared 32-bit multiplier, working registers and the result register.
module hcomp_dp import hcomp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_payload,
   input  cal_type cal,
   output rsp_type rsp_payload
);

   req_type            item_ff;
   logic signed [31:0] fine_ff, fine_in;
   logic signed [31:0] ra_ff, ra_in;
   logic signed [31:0] rb_ff, rb_in;
   logic signed [31:0] rc_ff, rc_in;
   rsp_type            rsp_ff, rsp_in;

   logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
   logic signed [31:0] adc_hum_sh, h4_sh, fine_v;
   logic signed [31:0] mul_a, mul_b, prod;
   logic signed [31:0] sum_left, sum_right, right_in, sq_base;

   logic signed [34:0] fine_ext, temp_sum;
   logic signed [26:0] temp_q;
   logic signed [23:0] temp_sat;
   logic signed [31:0] hum_clamped;

   // Calibration values widened to 32 bits, signed ones sign-extended
   assign t1 = {16'd0, cal.temp_cal_one};
   assign t2 = {{16{cal.temp_cal_two[15]}}, cal.temp_cal_two};
   assign t3 = {{16{cal.temp_cal_three[15]}}, cal.temp_cal_three};
   assign h1 = {24'd0, cal.hum_cal_one};
   assign h2 = {{16{cal.hum_cal_two[15]}}, cal.hum_cal_two};
   assign h3 = {24'd0, cal.hum_cal_three};
   assign h4 = {{20{cal.hum_cal_four_five[11]}}, cal.hum_cal_four_five[11:0]};
   assign h5 = {{20{cal.hum_cal_four_five[23]}}, cal.hum_cal_four_five[23:12]};
   assign h6 = {{24{cal.hum_cal_six[7]}}, cal.hum_cal_six};

   assign adc_hum_sh = {2'd0, item_ff.raw_value[15:0], 14'd0};
   assign h4_sh      = {h4[11:0], 20'd0};
   assign fine_v     = fine_ff - FINE_OFFSET;
   assign right_in   = (rb_ff >>> 10) + HUM_BIAS_R;
   assign sq_base    = ra_ff >>> 15;

   // Operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         STEP_T_LIN: begin
            mul_a = {15'd0, item_ff.raw_value[19:3]} - {15'd0, cal.temp_cal_one, 1'b0};
            mul_b = t2;
         end
         STEP_T_SQ: begin
            mul_a = {16'd0, item_ff.raw_value[19:4]} - t1;
            mul_b = {16'd0, item_ff.raw_value[19:4]} - t1;
         end
         STEP_T_FINE:  begin mul_a = rb_ff;    mul_b = t3;     end
         STEP_H_LEFT:  begin mul_a = h5;       mul_b = fine_v; end
         STEP_H_X:     begin mul_a = fine_v;   mul_b = h6;     end
         STEP_H_Y:     begin mul_a = fine_v;   mul_b = h3;     end
         STEP_H_INNER: begin mul_a = rb_ff;    mul_b = rc_ff;  end
         STEP_H_RIGHT: begin mul_a = right_in; mul_b = h2;     end
         STEP_H_PROD:  begin mul_a = ra_ff;    mul_b = rb_ff;  end
         STEP_H_SQ:    begin mul_a = sq_base;  mul_b = sq_base; end
         STEP_H_CORR:  begin mul_a = rb_ff;    mul_b = h1;     end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Low 32 bits only: every step wraps in two's complement
   assign prod      = mul_a * mul_b;
   assign sum_left  = adc_hum_sh - h4_sh - prod + HUM_ROUND_L;
   assign sum_right = prod + HUM_ROUND_R;

   always_comb begin
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      rc_in   = rc_ff;
      fine_in = fine_ff;
      if (cmd.exec) begin
         unique case (cmd.step)
            STEP_T_LIN:   ra_in   = prod >>> 11;
            STEP_T_SQ:    rb_in   = prod >>> 12;
            STEP_T_FINE:  fine_in = ra_ff + (prod >>> 14);
            STEP_H_LEFT:  ra_in   = sum_left >>> 15;
            STEP_H_X:     rb_in   = prod >>> 10;
            STEP_H_Y:     rc_in   = (prod >>> 11) + HUM_BIAS_Y;
            STEP_H_INNER: rb_in   = prod;
            STEP_H_RIGHT: rb_in   = sum_right >>> 14;
            STEP_H_PROD:  ra_in   = prod;
            STEP_H_SQ:    rb_in   = prod >>> 7;
            STEP_H_CORR:  ra_in   = ra_ff - (prod >>> 4);
            default:      ra_in   = ra_ff;
         endcase
      end
   end

   // Temperature: (fine * 5 + 128) >> 8 exactly, then saturated to 24 bits
   assign fine_ext = {{3{fine_ff[31]}}, fine_ff};
   assign temp_sum = (fine_ext <<< 2) + fine_ext + TEMP_ROUND;
   assign temp_q   = temp_sum[34:8];

   always_comb begin
      if (temp_q > TEMP_SAT_MAX) begin
         temp_sat = TEMP_SAT_MAX[23:0];
      end else if (temp_q < TEMP_SAT_MIN) begin
         temp_sat = TEMP_SAT_MIN[23:0];
      end else begin
         temp_sat = temp_q[23:0];
      end
   end

   always_comb begin
      if (ra_ff[31]) begin
         hum_clamped = '0;
      end else if (ra_ff > HUM_CLAMP_MAX) begin
         hum_clamped = HUM_CLAMP_MAX;
      end else begin
         hum_clamped = ra_ff;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.write_out) begin
         rsp_in.result_kind = item_ff.kind;
         if (item_ff.kind == KIND_HUMIDITY) begin
            rsp_in.temperature_centi = '0;
            rsp_in.humidity_q10      = hum_clamped[28:12];
            rsp_in.humidity_percent  = hum_clamped[28:22];
         end else begin
            rsp_in.temperature_centi = temp_sat;
            rsp_in.humidity_q10      = '0;
            rsp_in.humidity_percent  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_ff <= '0;
      end else begin
         fine_ff <= fine_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
      end
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      rc_ff  <= rc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/core/humidity_temperature_compensation_top.sv -----
// Top level of the humidity and temperature compensation block with its assertions.
//
// This block applies the 32-bit integer calibration formulas of combined
// temperature and humidity sensors to raw converter readings. A temperature
// item computes the fine temperature, keeps it for later humidity items and
// returns the temperature in hundredths of a degree, saturated to 24 bits
// signed. A humidity item uses the last fine temperature (zero after reset)
// and returns relative humidity in Q7.10, clamped to 0..100 %, together with
// its whole-percent value. Every intermediate step wraps in 32-bit two's
// complement. One 32-bit multiplier is shared across all steps and a small
// controller issues one step per cycle, so the throughput is set by the
// number of multiplications: a temperature item runs three multiply steps
// and a humidity item eight between its acceptance and the write of its
// result, and the block takes no new item until that write is done, as
// req_ready is only high in the idle state. The result sits in an output
// register; a new item is accepted while an earlier result still waits to be
// taken, and only the write of the next result waits for the output register
// to be free. The calibration registers are written through the csr_ port,
// which is always ready; writes to indexes above seven are ignored, and the
// registers must only be written while no item is in progress.
module humidity_temperature_compensation_top import hcomp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cal_type cal;
   cmd_type cmd;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;

   hcomp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cal       (cal)
   );

   hcomp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   hcomp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .cal         (cal),
      .rsp_payload (rsp_payload)
   );

   // Once an item is taken, the block is busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while the previous one is still in progress");

   // A temperature result carries no humidity.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.result_kind) |->
         (rsp_payload.humidity_q10 == '0 && rsp_payload.humidity_percent == '0))
      else $error("temperature result with non-zero humidity fields");

   // A humidity result is clamped and its percent field agrees with Q7.10.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.result_kind) |->
         (rsp_payload.humidity_q10 <= 17'd102400 &&
          rsp_payload.humidity_percent == rsp_payload.humidity_q10[16:10] &&
          rsp_payload.temperature_centi == '0))
      else $error("humidity result out of range or inconsistent");

   // A result only changes once the previous one has been taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_payload))
      else $error("result register overwritten before it was taken");

endmodule
